@@ hdl/heightmap_text_point_parser_core_assert.svh @@
// assertion macros used by the height map parser core
`ifndef HEIGHTMAP_TEXT_POINT_PARSER_CORE_ASSERT_SVH
`define HEIGHTMAP_TEXT_POINT_PARSER_CORE_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define HMTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hmtp assertion failed");

// next-cycle implication, checked on every clock outside reset
`define HMTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hmtp assertion failed");

`endif

@@ hdl/hmtp_pkg.sv @@
// shared point type, character codes and defaults of the height map parser
`default_nettype none

package hmtp_pkg;

    // parameter defaults
    localparam int GRID_STEP_DEF   = 20;
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ROWS_DEF    = 1024;

    // register map
    localparam logic [2:0]  ADDR_DEFAULT_COLOR  = 3'd0;
    localparam logic [31:0] DEFAULT_COLOR_RESET = 32'h00FF_FFFF;

    // character codes
    localparam logic [7:0] CH_END     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;

    // one finished point
    typedef struct packed {
        logic [14:0]        pos_x;
        logic [14:0]        pos_y;
        logic signed [31:0] height;
        logic [31:0]        color;
        logic               last_point;
    } t_point;

endpackage

`default_nettype wire

@@ hdl/heightmap_text_point_parser_core.sv @@
// Height map text parser: takes one map byte per clock while o_stall is low (space
// separates tokens, newline ends a row, byte 0 ends the map) and gives one point
// word per closed token. The byte that closes a token loads its point word into the
// output register, or into the skid entry if the output register holds a waiting point,
// at the same edge that takes it. Points pass through an output register and one skid
// entry, so bytes keep flowing while one point waits. o_stall is raised only while the
// skid entry holds a word, and drops the cycle after the downstream side takes the
// waiting point. default_color is written over the APB port at byte address 0.
`default_nettype none

module heightmap_text_point_parser_core
    import hmtp_pkg::*;
#(
    parameter int GRID_STEP   = GRID_STEP_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_in,
    // point output
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [14:0]      o_pos_x,
    output logic [14:0]      o_pos_y,
    output logic signed [31:0] o_height,
    output logic [31:0]      o_color,
    output logic             o_last_point,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

`include "heightmap_text_point_parser_core_assert.svh"

    logic [31:0] r_default_color;
    t_point      r_out, r_skid;
    logic        r_out_valid, r_skid_valid;
    logic        in_accept, out_pop, emit;
    t_point      point;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DEFAULT_COLOR) ? r_default_color : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_color <= DEFAULT_COLOR_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_DEFAULT_COLOR) begin
            r_default_color <= pwdata;
        end
    end

    // handshakes
    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !r_skid_valid;
    assign out_pop   = r_out_valid && !i_stall;

    hmtp_parser #(
        .GRID_STEP   (GRID_STEP),
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_char          (i_char_in),
        .i_default_color (r_default_color),
        .o_emit          (emit),
        .o_point         (point)
    );

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (emit) begin
            if (!r_out_valid || out_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // word payloads
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (emit) begin
            if (!r_out_valid || out_pop) begin
                r_out <= point;
            end else begin
                r_skid <= point;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pos_x      = r_out.pos_x;
    assign o_pos_y      = r_out.pos_y;
    assign o_height     = r_out.height;
    assign o_color      = r_out.color;
    assign o_last_point = r_out.last_point;

    // skid entry only fills behind a waiting word
    `HMTP_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // a taken word with the skid full moves the skid word up and frees it
    `HMTP_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid_valid && !i_stall,
        r_out_valid && !r_skid_valid)
    // a new word behind a stalled word lands in the skid entry
    `HMTP_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n,
        emit && r_out_valid && i_stall && !r_skid_valid, r_skid_valid && r_out_valid)
    // no byte is taken while the skid entry is full
    `HMTP_ASSERT_NOW(a_no_take_when_full, i_clk, i_rst_n, r_skid_valid, !in_accept && !emit)

endmodule

`default_nettype wire

@@ hdl/hmtp_parser.sv @@
// token parser: per-byte state update and point assembly
`default_nettype none

module hmtp_parser
    import hmtp_pkg::*;
#(
    parameter int GRID_STEP   = GRID_STEP_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_char,
    input  wire logic [31:0] i_default_color,
    output logic             o_emit,
    output t_point           o_point
);

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

    // parse phase codes
    localparam logic [2:0] PH_BETWEEN = 3'd0;
    localparam logic [2:0] PH_HEIGHT  = 3'd1;
    localparam logic [2:0] PH_SKIP    = 3'd2;
    localparam logic [2:0] PH_HEX     = 3'd3;
    localparam logic [2:0] PH_JUNK    = 3'd4;

    logic [2:0]       r_phase, n_phase;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [31:0]      r_height, n_height;
    logic             r_neg, n_neg;
    logic [31:0]      r_color, n_color;
    logic             r_has_color, n_has_color;
    logic [1:0]       r_skip, n_skip;

    logic [2:0] v_phase;
    logic       v_sign_only;
    logic       v_last;
    logic [4:0] v_hex;

    // hex digit decode: valid bit over the nibble value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[CH_0:CH_9]}) begin
            r = {1'b1, 4'(c - CH_0)};
        end else if (c inside {[CH_UA:CH_UF]}) begin
            r = {1'b1, 4'(c - CH_UA + 8'd10)};
        end else if (c inside {[CH_LA:CH_LF]}) begin
            r = {1'b1, 4'(c - CH_LA + 8'd10)};
        end
        return r;
    endfunction

    assign v_hex = hex_decode(i_char);

    // next state for one accepted byte
    always_comb begin
        n_phase     = r_phase;
        n_col       = r_col;
        n_row       = r_row;
        n_height    = r_height;
        n_neg       = r_neg;
        n_color     = r_color;
        n_has_color = r_has_color;
        n_skip      = r_skip;
        v_phase     = r_phase;
        v_sign_only = 1'b0;
        o_emit      = 1'b0;
        v_last      = 1'b0;
        if (i_accept) begin
            if (i_char == CH_END) begin
                // end of map: flush open token, go back to origin
                o_emit      = (r_phase != PH_BETWEEN);
                v_last      = 1'b1;
                n_phase     = PH_BETWEEN;
                n_col       = '0;
                n_row       = '0;
                n_height    = '0;
                n_neg       = 1'b0;
                n_color     = '0;
                n_has_color = 1'b0;
                n_skip      = '0;
            end else if (i_char == CH_SPACE || i_char == CH_NEWLINE) begin
                if (r_phase != PH_BETWEEN) begin
                    o_emit      = 1'b1;
                    n_phase     = PH_BETWEEN;
                    n_height    = '0;
                    n_neg       = 1'b0;
                    n_color     = '0;
                    n_has_color = 1'b0;
                    n_skip      = '0;
                    if (r_col < COL_LAST) begin
                        n_col = r_col + 1'b1;
                    end
                end
                if (i_char == CH_NEWLINE) begin
                    n_col = '0;
                    if (r_row < ROW_LAST) begin
                        n_row = r_row + 1'b1;
                    end
                end
            end else begin
                // token byte; a leading minus only sets the sign
                if (r_phase == PH_BETWEEN) begin
                    v_phase = PH_HEIGHT;
                    n_phase = PH_HEIGHT;
                    if (i_char == CH_MINUS) begin
                        n_neg       = 1'b1;
                        v_sign_only = 1'b1;
                    end
                end
                if (!v_sign_only) begin
                    case (v_phase)
                        PH_HEIGHT: begin
                            if (i_char inside {[CH_0:CH_9]}) begin
                                n_height = (r_height << 3) + (r_height << 1)
                                         + 32'(i_char - CH_0);
                            end else if (i_char == CH_COMMA) begin
                                n_has_color = 1'b1;
                                n_color     = '0;
                                n_skip      = 2'd2;
                                n_phase     = PH_SKIP;
                            end else begin
                                n_phase = PH_JUNK;
                            end
                        end
                        PH_SKIP: begin
                            n_skip = (r_skip != 2'd0) ? r_skip - 2'd1 : 2'd0;
                            if (n_skip == 2'd0) begin
                                n_phase = PH_HEX;
                            end
                        end
                        PH_HEX: begin
                            if (v_hex[4]) begin
                                n_color = {r_color[27:0], v_hex[3:0]};
                            end else begin
                                n_phase = PH_JUNK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    // point built from the state before this byte
    always_comb begin
        o_point.pos_x      = 15'(r_col) * 15'(GRID_STEP);
        o_point.pos_y      = 15'(r_row) * 15'(GRID_STEP);
        o_point.height     = r_neg ? (32'sd0 - $signed(r_height)) : $signed(r_height);
        o_point.color      = r_has_color ? r_color : i_default_color;
        o_point.last_point = v_last;
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_BETWEEN;
            r_col       <= '0;
            r_row       <= '0;
            r_height    <= '0;
            r_neg       <= 1'b0;
            r_color     <= '0;
            r_has_color <= 1'b0;
            r_skip      <= '0;
        end else begin
            r_phase     <= n_phase;
            r_col       <= n_col;
            r_row       <= n_row;
            r_height    <= n_height;
            r_neg       <= n_neg;
            r_color     <= n_color;
            r_has_color <= n_has_color;
            r_skip      <= n_skip;
        end
    end

endmodule

`default_nettype wire
